// ===== rtl/core/gsms_pkg.sv =====
// Shared types, constants and helpers of the gantry square move sequencer.
package gsms_pkg;

  // Board size (squares per side) and field widths
  localparam int BOARD_SIDE = 8;
  localparam int COORD_W    = 3;
  localparam int SQ_W       = 3;
  localparam int STEPS_W    = 12;
  localparam int HALF_W     = 16;
  localparam int PAUSE_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_STRAIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_DIAGONAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE          = 2'd3;

  // Register reset values
  localparam logic [STEPS_W-1:0] STEPS_STRAIGHT_RST = 12'd180;
  localparam logic [STEPS_W-1:0] STEPS_DIAGONAL_RST = 12'd360;
  localparam logic [HALF_W-1:0]  HALF_PERIOD_RST    = 16'd1000;
  localparam logic [PAUSE_W-1:0] PAUSE_RST          = 20'd500000;

  // Request types
  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Motor patterns, bit order {power_b, power_a, dir_b, dir_a}
  localparam logic [3:0] PAT_RIGHT    = 4'b1110;
  localparam logic [3:0] PAT_LEFT     = 4'b1101;
  localparam logic [3:0] PAT_UP       = 4'b1100;
  localparam logic [3:0] PAT_DOWN     = 4'b1111;
  localparam logic [3:0] PAT_DIAG_PP  = 4'b0101;
  localparam logic [3:0] PAT_DIAG_NN  = 4'b0100;
  localparam logic [3:0] PAT_DIAG_PN  = 4'b1010;
  localparam logic [3:0] PAT_DIAG_NP  = 4'b1000;

  // Per-square timing phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

  // Configuration register set
  typedef struct packed {
    logic [STEPS_W-1:0] steps_straight;
    logic [STEPS_W-1:0] steps_diagonal;
    logic [HALF_W-1:0]  half_period_ticks;
    logic [PAUSE_W-1:0] pause_ticks;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] target_file;
    logic [COORD_W-1:0] target_rank;
  } req_t;

  // One result
  typedef struct packed {
    logic dir_a;
    logic dir_b;
    logic step_a;
    logic step_b;
    logic busy_res;
    logic move_done;
    logic rejected;
  } res_t;

  // Saturate a target coordinate to the last square of the board
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W+1:0] side;
    side = (COORD_W+2)'(BOARD_SIDE);
    if ((COORD_W+2)'(v) >= side) begin
      clamp_coord = COORD_W'(BOARD_SIDE - 1);
    end else begin
      clamp_coord = v;
    end
  endfunction

endpackage

// ===== rtl/core/gsms_req_if.sv =====
// Request channel interface: valid/ready handshake with move or tick payload.
interface gsms_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [gsms_pkg::COORD_W-1:0] target_file;
  logic [gsms_pkg::COORD_W-1:0] target_rank;

  modport source (output valid, output req_type, output target_file,
                  output target_rank, input ready);
  modport sink   (input valid, input req_type, input target_file,
                  input target_rank, output ready);
endinterface

// ===== rtl/core/gsms_res_if.sv =====
// Result channel interface: valid/ready handshake with pin and status payload.
interface gsms_res_if;
  logic valid;
  logic ready;
  logic dir_a;
  logic dir_b;
  logic step_a;
  logic step_b;
  logic busy_res;
  logic move_done;
  logic rejected;

  modport source (output valid, output dir_a, output dir_b, output step_a,
                  output step_b, output busy_res, output move_done,
                  output rejected, input ready);
  modport sink   (input valid, input dir_a, input dir_b, input step_a,
                  input step_b, input busy_res, input move_done,
                  input rejected, output ready);
endinterface

// ===== rtl/core/gantry_square_move_sequencer.sv =====
// Gantry square move sequencer: one request per clock through an input
// register, a single-pass sequencer core and a result register. Each request
// (a move to a target square, or one time tick) yields exactly one result
// after passing the input register and the result register, and a new
// request is taken every cycle while the result side keeps up; throughput is
// set by the state update of the core. Move requests that arrive while a move
// is running are dropped and flagged as rejected. Configuration writes take
// effect on the next cycle and are meant for idle periods.
module gantry_square_move_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  gsms_req_if.sink                        in_req,
  gsms_res_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [gsms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gsms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gsms_pkg::cfg_t cfg;
  gsms_pkg::req_t req_r, req_nxt;
  gsms_pkg::res_t res_r, core_res;
  logic           req_valid_r, res_valid_r;
  logic           adv, in_ready;

  gsms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance a request into the result register when that register is free or being read out
  assign adv      = req_valid_r && (!res_valid_r || out_res.ready);
  assign in_ready = !req_valid_r || adv;
  assign in_req.ready = in_ready;

  assign req_nxt.req_type    = in_req.req_type;
  assign req_nxt.target_file = in_req.target_file;
  assign req_nxt.target_rank = in_req.target_rank;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_req.valid) begin
      req_r <= req_nxt;
    end
  end

  gsms_seq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .req     (req_r),
    .cfg     (cfg),
    .res     (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= core_res;
    end
  end

  assign out_res.valid     = res_valid_r;
  assign out_res.dir_a     = res_r.dir_a;
  assign out_res.dir_b     = res_r.dir_b;
  assign out_res.step_a    = res_r.step_a;
  assign out_res.step_b    = res_r.step_b;
  assign out_res.busy_res  = res_r.busy_res;
  assign out_res.move_done = res_r.move_done;
  assign out_res.rejected  = res_r.rejected;

endmodule

// ===== rtl/core/gsms_cfg_regs.sv =====
// Configuration register file of the sequencer.
module gsms_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gsms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gsms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output gsms_pkg::cfg_t                  cfg
);

  gsms_pkg::cfg_t cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps_straight    <= gsms_pkg::STEPS_STRAIGHT_RST;
      cfg_r.steps_diagonal    <= gsms_pkg::STEPS_DIAGONAL_RST;
      cfg_r.half_period_ticks <= gsms_pkg::HALF_PERIOD_RST;
      cfg_r.pause_ticks       <= gsms_pkg::PAUSE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        gsms_pkg::CFG_STEPS_STRAIGHT: cfg_r.steps_straight    <= cfg_wdata[gsms_pkg::STEPS_W-1:0];
        gsms_pkg::CFG_STEPS_DIAGONAL: cfg_r.steps_diagonal    <= cfg_wdata[gsms_pkg::STEPS_W-1:0];
        gsms_pkg::CFG_HALF_PERIOD:    cfg_r.half_period_ticks <= cfg_wdata[gsms_pkg::HALF_W-1:0];
        gsms_pkg::CFG_PAUSE:          cfg_r.pause_ticks       <= cfg_wdata[gsms_pkg::PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/gsms_seq_core.sv =====
// Move planner and pulse timing state machine: one request per enabled cycle.
module gsms_seq_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  gsms_pkg::req_t req,
  input  gsms_pkg::cfg_t cfg,
  output gsms_pkg::res_t res
);

  logic [gsms_pkg::COORD_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  gsms_pkg::phase_t             phase_r, phase_nxt;
  logic [3:0]                   pattern_r, pattern_nxt, leg2_pattern_r, leg2_pattern_nxt;
  logic [gsms_pkg::SQ_W-1:0]    squares_left_r, squares_left_nxt;
  logic [gsms_pkg::SQ_W-1:0]    leg2_squares_r, leg2_squares_nxt;
  logic [gsms_pkg::STEPS_W-1:0] step_count_r, step_count_nxt;
  logic [gsms_pkg::PAUSE_W-1:0] delay_count_r, delay_count_nxt;
  logic [1:0]                   dir_latch_r, dir_latch_nxt;

  // Planner and timing temporaries
  logic [gsms_pkg::COORD_W-1:0] tx, ty;
  logic signed [gsms_pkg::COORD_W:0] dx, dy, ndy;
  logic [gsms_pkg::SQ_W-1:0]    adx, ady, sl_dec;
  logic [3:0]                   ypat, begin_pat;
  logic                         do_begin, end_sq;
  logic [gsms_pkg::STEPS_W-1:0] steps_sel, steps_load, sc_dec;
  logic [gsms_pkg::HALF_W-1:0]  half_load;
  logic [gsms_pkg::PAUSE_W-1:0] dc_dec;
  logic                         sa, sb, done, rej;

  always_comb begin
    // Hold by default
    pos_x_nxt        = pos_x_r;
    pos_y_nxt        = pos_y_r;
    phase_nxt        = phase_r;
    pattern_nxt      = pattern_r;
    leg2_pattern_nxt = leg2_pattern_r;
    squares_left_nxt = squares_left_r;
    leg2_squares_nxt = leg2_squares_r;
    step_count_nxt   = step_count_r;
    delay_count_nxt  = delay_count_r;
    dir_latch_nxt    = dir_latch_r;
    sa               = 1'b0;
    sb               = 1'b0;
    done             = 1'b0;
    rej              = 1'b0;
    do_begin         = 1'b0;
    end_sq           = 1'b0;
    begin_pat        = pattern_r;

    // Target and deltas from the stored position
    tx  = gsms_pkg::clamp_coord(req.target_file);
    ty  = gsms_pkg::clamp_coord(req.target_rank);
    dx  = $signed({1'b0, tx}) - $signed({1'b0, pos_x_r});
    dy  = $signed({1'b0, ty}) - $signed({1'b0, pos_y_r});
    ndy = -dy;
    adx = dx[gsms_pkg::COORD_W] ? gsms_pkg::SQ_W'(-dx) : gsms_pkg::SQ_W'(dx);
    ady = dy[gsms_pkg::COORD_W] ? gsms_pkg::SQ_W'(ndy) : gsms_pkg::SQ_W'(dy);
    ypat = (dy > 0) ? gsms_pkg::PAT_UP : gsms_pkg::PAT_DOWN;

    // Counter decrements
    dc_dec = (delay_count_r != '0) ? delay_count_r - 1'b1 : '0;
    sc_dec = (step_count_r != '0) ? step_count_r - 1'b1 : '0;
    sl_dec = (squares_left_r != '0) ? squares_left_r - 1'b1 : '0;
    half_load = (cfg.half_period_ticks == '0) ? gsms_pkg::HALF_W'(1) : cfg.half_period_ticks;

    if (step_en) begin
      if (req.req_type == gsms_pkg::REQ_MOVE) begin
        if (phase_r != gsms_pkg::PH_IDLE) begin
          // Drop a request that arrives mid-move
          rej = 1'b1;
        end else begin
          // Plan the move: one diagonal leg, or an X leg then a Y leg (either may be absent)
          pos_x_nxt        = tx;
          pos_y_nxt        = ty;
          leg2_squares_nxt = '0;
          if (dx == dy) begin
            begin_pat        = (dx > 0) ? gsms_pkg::PAT_DIAG_PP : gsms_pkg::PAT_DIAG_NN;
            squares_left_nxt = adx;
          end else if (dx == ndy) begin
            begin_pat        = (dx > 0) ? gsms_pkg::PAT_DIAG_PN : gsms_pkg::PAT_DIAG_NP;
            squares_left_nxt = adx;
          end else if (dx != 0) begin
            begin_pat        = (dx > 0) ? gsms_pkg::PAT_RIGHT : gsms_pkg::PAT_LEFT;
            squares_left_nxt = adx;
            leg2_pattern_nxt = ypat;
            leg2_squares_nxt = ady;
          end else begin
            begin_pat        = ypat;
            squares_left_nxt = ady;
          end
          pattern_nxt = begin_pat;
          if (squares_left_nxt == '0) begin
            phase_nxt = gsms_pkg::PH_IDLE;
            done      = 1'b1;
          end else begin
            do_begin = 1'b1;
          end
        end
      end else if (phase_r != gsms_pkg::PH_IDLE) begin
        // Drive step pins in the high phase, then advance time
        if (phase_r == gsms_pkg::PH_HIGH) begin
          sa = pattern_r[2];
          sb = pattern_r[3];
        end
        delay_count_nxt = dc_dec;
        if (dc_dec == '0) begin
          case (phase_r)
            gsms_pkg::PH_HIGH: begin
              phase_nxt       = gsms_pkg::PH_LOW;
              delay_count_nxt = gsms_pkg::PAUSE_W'(half_load);
            end
            gsms_pkg::PH_LOW: begin
              step_count_nxt = sc_dec;
              if (sc_dec != '0) begin
                phase_nxt       = gsms_pkg::PH_HIGH;
                delay_count_nxt = gsms_pkg::PAUSE_W'(half_load);
              end else if (cfg.pause_ticks != '0) begin
                phase_nxt       = gsms_pkg::PH_PAUSE;
                delay_count_nxt = cfg.pause_ticks;
              end else begin
                end_sq = 1'b1;
              end
            end
            gsms_pkg::PH_PAUSE: end_sq = 1'b1;
            default: ;
          endcase
        end
        // Advance to the next square, the second leg, or finish
        if (end_sq) begin
          squares_left_nxt = sl_dec;
          if (sl_dec != '0) begin
            do_begin = 1'b1;
          end else if (leg2_squares_r != '0) begin
            begin_pat        = leg2_pattern_r;
            pattern_nxt      = leg2_pattern_r;
            squares_left_nxt = leg2_squares_r;
            leg2_squares_nxt = '0;
            do_begin         = 1'b1;
          end else begin
            phase_nxt = gsms_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
      end
    end

    // Start a square: latch direction, load pulse counters
    steps_sel  = (begin_pat[2] != begin_pat[3]) ? cfg.steps_diagonal : cfg.steps_straight;
    steps_load = (steps_sel == '0) ? gsms_pkg::STEPS_W'(1) : steps_sel;
    if (do_begin) begin
      dir_latch_nxt   = begin_pat[1:0];
      step_count_nxt  = steps_load;
      delay_count_nxt = gsms_pkg::PAUSE_W'(half_load);
      phase_nxt       = gsms_pkg::PH_HIGH;
    end

    res.dir_a     = dir_latch_nxt[0];
    res.dir_b     = dir_latch_nxt[1];
    res.step_a    = sa;
    res.step_b    = sb;
    res.busy_res  = (phase_nxt != gsms_pkg::PH_IDLE);
    res.move_done = done;
    res.rejected  = rej;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r        <= '0;
      pos_y_r        <= '0;
      phase_r        <= gsms_pkg::PH_IDLE;
      pattern_r      <= '0;
      leg2_pattern_r <= '0;
      squares_left_r <= '0;
      leg2_squares_r <= '0;
      step_count_r   <= '0;
      delay_count_r  <= '0;
      dir_latch_r    <= '0;
    end else begin
      pos_x_r        <= pos_x_nxt;
      pos_y_r        <= pos_y_nxt;
      phase_r        <= phase_nxt;
      pattern_r      <= pattern_nxt;
      leg2_pattern_r <= leg2_pattern_nxt;
      squares_left_r <= squares_left_nxt;
      leg2_squares_r <= leg2_squares_nxt;
      step_count_r   <= step_count_nxt;
      delay_count_r  <= delay_count_nxt;
      dir_latch_r    <= dir_latch_nxt;
    end
  end

endmodule
